// ===== hw/rtl/laptop_power_sequencer_macros.svh =====
// assertion macros for the laptop power sequencer
// used by laptop_power_sequencer.sv, expects clk and rst_n in scope
`ifndef LAPTOP_POWER_SEQUENCER_MACROS_SVH
`define LAPTOP_POWER_SEQUENCER_MACROS_SVH

// antecedent and consequent in the same cycle
`define LPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lps_pkg.sv =====
// shared types and constants of the laptop power sequencer
// no dependencies, imported by laptop_power_sequencer
package lps_pkg;

  localparam int TIMER_WIDTH_DEF = 20;
  localparam int CFG_W           = 20;
  localparam int REG_NUM         = 8;
  localparam int REG_IDX_W       = 3;
  localparam int PADDR_W         = 5;
  localparam int PDATA_W         = 32;
  localparam int PIN_W           = 12;

  // configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_DS5_WAIT    = 3'd0,
    REG_PRIM_VDD5   = 3'd1,
    REG_VDD5_RSM    = 3'd2,
    REG_RSM_ENABLE  = 3'd3,
    REG_SETTLE      = 3'd4,
    REG_DEBOUNCE    = 3'd5,
    REG_PWRGD_SYSOK = 3'd6,
    REG_BLINK       = 3'd7
  } reg_idx_t;

  // platform power level
  typedef enum logic [2:0] {
    LV_DEFAULT = 3'd0,
    LV_DS5     = 3'd1,
    LV_S5      = 3'd2,
    LV_S3      = 3'd3,
    LV_S0      = 3'd4
  } level_t;

  // sequencer steps; the low codes are also the resume points of a wait
  typedef enum logic [4:0] {
    ST_IDLE     = 5'd0,
    ST_DS5      = 5'd1,
    ST_DEBOUNCE = 5'd2,
    ST_S5_A     = 5'd3,
    ST_S5_B     = 5'd4,
    ST_S5_C     = 5'd5,
    ST_S5_D     = 5'd6,
    ST_SYSOK    = 5'd7,
    ST_OFF_A    = 5'd8,
    ST_OFF_B    = 5'd9,
    ST_START    = 5'd20,
    ST_ADAPTER  = 5'd21,
    ST_S5       = 5'd22,
    ST_GOOD     = 5'd23,
    ST_RESET    = 5'd24,
    ST_LEDS     = 5'd25
  } step_t;

  // bit positions in the pin state word
  localparam int PIN_PRIM   = 0;
  localparam int PIN_VDD5   = 1;
  localparam int PIN_SUSACK = 2;
  localparam int PIN_DSW    = 3;
  localparam int PIN_RSM    = 4;
  localparam int PIN_CTL    = 5;
  localparam int PIN_PCHOK  = 6;
  localparam int PIN_SYSOK  = 7;
  localparam int PIN_BTN    = 8;
  localparam int PIN_LEDP   = 9;
  localparam int PIN_LEDA   = 10;
  localparam int PIN_CHG    = 11;

  function automatic logic [CFG_W-1:0] reg_default(input reg_idx_t idx);
    logic [CFG_W-1:0] v;
    case (idx)
      REG_DS5_WAIT:    v = CFG_W'(9000);
      REG_PRIM_VDD5:   v = CFG_W'(200);
      REG_VDD5_RSM:    v = CFG_W'(10000);
      REG_RSM_ENABLE:  v = CFG_W'(95000);
      REG_SETTLE:      v = CFG_W'(400000);
      REG_DEBOUNCE:    v = CFG_W'(10000);
      REG_PWRGD_SYSOK: v = CFG_W'(10000);
      REG_BLINK:       v = CFG_W'(1000000);
      default:         v = '0;
    endcase
    return v;
  endfunction

  function automatic level_t level_of(input logic susb_n, input logic susc_n,
                                      input logic rsm);
    level_t lv;
    if (susb_n) begin
      lv = LV_S0;
    end else if (susc_n) begin
      lv = LV_S3;
    end else if (rsm) begin
      lv = LV_S5;
    end else begin
      lv = LV_DS5;
    end
    return lv;
  endfunction

endpackage

// ===== hw/rtl/laptop_power_sequencer.sv =====
// Laptop power sequencer. Takes one request per clock, each request being one
// microsecond tick of sampled pins, and returns one result per request in the cycle
// after it is taken; the whole tick is evaluated by a single pass of logic between
// the state registers and the result register, so the sustained rate is one
// request per cycle whenever the result side keeps up. Timed rail steps (DS5 entry,
// S5 power-on, power-off, debounce, system power ok) are counted in requests, not
// clocks: while a wait counts, each request only decrements the timer, steps the blink
// counter and reports waiting. Configuration registers are APB-writable at byte
// address 4*index and must be changed only while no request is outstanding.
// depends on lps_pkg and laptop_power_sequencer_macros.svh
`include "laptop_power_sequencer_macros.svh"

module laptop_power_sequencer #(
  parameter int TIMER_WIDTH = lps_pkg::TIMER_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_susb_n,
  input  logic                         in_susc_n,
  input  logic                         in_acin_n,
  input  logic                         in_power_sw_n,
  input  logic                         in_lid_open,
  input  logic                         in_rails_good,
  input  logic                         in_plt_rst_n,
  input  logic                         in_sus_warn_n,
  input  logic                         in_sci_accept,
  // result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [5:0]                   out_rail_enables,
  output logic [1:0]                   out_pwrok_pins,
  output logic                         out_power_button_n,
  output logic                         out_led_power,
  output logic                         out_led_adapter,
  output logic                         out_charger_enable,
  output logic                         out_sci_send,
  output logic                         out_refresh_request,
  output logic                         out_pnp_enable_pulse,
  output logic [2:0]                   out_power_level,
  output logic                         out_waiting,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lps_pkg::PADDR_W-1:0]  paddr,
  input  logic [lps_pkg::PDATA_W-1:0]  pwdata,
  output logic [lps_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import lps_pkg::*;

  localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  function automatic logic [TIMER_WIDTH-1:0] to_tw(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] t;
    t = CMP_W'(v);
    return t[TIMER_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [CFG_W-1:0]       cfg_r [REG_NUM];
  reg_idx_t               cfg_idx;
  logic                   cfg_wr;

  // sequencer state
  level_t                 level_r, level_nxt;
  step_t                  phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] wcount_r, wcount_nxt;
  logic [TIMER_WIDTH-1:0] blink_r, blink_nxt;
  logic                   adapter_r, adapter_nxt;
  logic                   scip_r, scip_nxt;
  logic                   button_r, button_nxt;
  logic                   pwrgd_r, pwrgd_nxt;
  logic                   rstlast_r, rstlast_nxt;
  logic [PIN_W-1:0]       pins_r, pins_nxt;

  // result handshake and pulses
  logic                   out_valid_r, out_valid_nxt;
  logic                   sci_r, refresh_r, pnp_r;
  logic                   sci_nxt, refresh_nxt, pnp_nxt;
  logic                   in_fire;

  // evaluation scratch
  step_t                  pt;
  logic                   done;
  logic                   ps;
  logic [TIMER_WIDTH-1:0] w_ds5, w_prim, w_vdd5, w_rsm, w_settle, w_deb, w_sysok;

  // assertion helpers
  logic                   wait_step;
  logic [TIMER_WIDTH-1:0] wcount_dec;
  logic                   sci_src;

  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = PDATA_W'(cfg_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_NUM; i++) begin
        cfg_r[i] <= reg_default(reg_idx_t'(i));
      end
    end else if (cfg_wr) begin
      cfg_r[cfg_idx] <= pwdata[CFG_W-1:0];
    end
  end

  assign w_ds5    = to_tw(cfg_r[REG_DS5_WAIT]);
  assign w_prim   = to_tw(cfg_r[REG_PRIM_VDD5]);
  assign w_vdd5   = to_tw(cfg_r[REG_VDD5_RSM]);
  assign w_rsm    = to_tw(cfg_r[REG_RSM_ENABLE]);
  assign w_settle = to_tw(cfg_r[REG_SETTLE]);
  assign w_deb    = to_tw(cfg_r[REG_DEBOUNCE]);
  assign w_sysok  = to_tw(cfg_r[REG_PWRGD_SYSOK]);

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // one tick: every step jumps forward, so the steps are laid out in order
  always_comb begin
    level_nxt   = level_r;
    phase_nxt   = phase_r;
    wcount_nxt  = wcount_r;
    adapter_nxt = adapter_r;
    scip_nxt    = scip_r;
    button_nxt  = button_r;
    pwrgd_nxt   = pwrgd_r;
    rstlast_nxt = rstlast_r;
    pins_nxt    = pins_r;
    sci_nxt     = 1'b0;
    refresh_nxt = 1'b0;
    pnp_nxt     = 1'b0;
    ps          = button_r;
    pt          = ST_START;
    done        = 1'b0;

    if (blink_r != '1) begin
      blink_nxt = blink_r + 1'b1;
    end else begin
      blink_nxt = blink_r;
    end

    if (phase_r != ST_IDLE) begin
      if (wcount_r > TIMER_WIDTH'(1)) begin
        wcount_nxt = wcount_r - 1'b1;
        done       = 1'b1;
      end else begin
        wcount_nxt = '0;
        pt         = phase_r;
        phase_nxt  = ST_IDLE;
      end
    end

    if (!done && pt == ST_START) begin
      if (level_r == LV_DEFAULT) begin
        if (w_ds5 != '0) begin
          phase_nxt = ST_DS5; wcount_nxt = w_ds5; done = 1'b1;
        end else begin
          pt = ST_DS5;
        end
      end else begin
        pt = ST_ADAPTER;
      end
    end

    if (!done && pt == ST_DS5) begin
      level_nxt = level_of(in_susb_n, in_susc_n, pins_nxt[PIN_RSM]);
      pt        = ST_ADAPTER;
    end

    if (!done && pt == ST_ADAPTER) begin
      if (in_acin_n != adapter_r) begin
        pins_nxt[PIN_CHG] = !in_acin_n;
        refresh_nxt       = 1'b1;
        scip_nxt          = 1'b1;
      end
      if (scip_nxt && in_sci_accept) begin
        sci_nxt  = 1'b1;
        scip_nxt = 1'b0;
      end
      adapter_nxt = in_acin_n;
      // lid closed on battery masks the button
      ps = in_power_sw_n || (!in_lid_open && in_acin_n);
      if (!ps && button_r) begin
        if (w_deb != '0) begin
          phase_nxt = ST_DEBOUNCE; wcount_nxt = w_deb; done = 1'b1;
        end else begin
          pt = ST_DEBOUNCE;
        end
      end else begin
        pt = ST_GOOD;
      end
    end

    if (!done && pt == ST_DEBOUNCE) begin
      if (in_power_sw_n) begin
        ps = button_r;
        pt = ST_GOOD;
      end else begin
        ps        = 1'b0;
        level_nxt = level_of(in_susb_n, in_susc_n, pins_nxt[PIN_RSM]);
        pt        = (level_nxt == LV_DS5) ? ST_S5 : ST_GOOD;
      end
    end

    if (!done && pt == ST_S5) begin
      pins_nxt[PIN_PRIM] = 1'b1;
      if (w_prim != '0) begin
        phase_nxt = ST_S5_A; wcount_nxt = w_prim; done = 1'b1;
      end else begin
        pt = ST_S5_A;
      end
    end

    if (!done && pt == ST_S5_A) begin
      pins_nxt[PIN_VDD5]   = 1'b1;
      pins_nxt[PIN_SUSACK] = 1'b1;
      if (w_vdd5 != '0) begin
        phase_nxt = ST_S5_B; wcount_nxt = w_vdd5; done = 1'b1;
      end else begin
        pt = ST_S5_B;
      end
    end

    if (!done && pt == ST_S5_B) begin
      pins_nxt[PIN_DSW] = 1'b1;
      pins_nxt[PIN_RSM] = 1'b1;
      if (w_rsm != '0) begin
        phase_nxt = ST_S5_C; wcount_nxt = w_rsm; done = 1'b1;
      end else begin
        pt = ST_S5_C;
      end
    end

    if (!done && pt == ST_S5_C) begin
      pins_nxt[PIN_CTL] = 1'b1;
      if (w_settle != '0) begin
        phase_nxt = ST_S5_D; wcount_nxt = w_settle; done = 1'b1;
      end else begin
        pt = ST_S5_D;
      end
    end

    if (!done && pt == ST_S5_D) begin
      level_nxt = level_of(in_susb_n, in_susc_n, pins_nxt[PIN_RSM]);
      ps        = 1'b0;
      pt        = ST_GOOD;
    end

    if (!done && pt == ST_GOOD) begin
      button_nxt        = ps;
      pins_nxt[PIN_BTN] = ps;
      level_nxt         = level_of(in_susb_n, in_susc_n, pins_nxt[PIN_RSM]);
      if (in_rails_good && !pwrgd_r) begin
        pwrgd_nxt           = 1'b1;
        pins_nxt[PIN_PCHOK] = 1'b1;
        if (w_sysok != '0) begin
          phase_nxt = ST_SYSOK; wcount_nxt = w_sysok; done = 1'b1;
        end else begin
          pt = ST_SYSOK;
        end
      end else begin
        if (!in_rails_good && pwrgd_r) begin
          pins_nxt[PIN_PCHOK] = 1'b0;
          pins_nxt[PIN_SYSOK] = 1'b0;
        end
        pwrgd_nxt = in_rails_good;
        pt        = ST_RESET;
      end
    end

    if (!done && pt == ST_SYSOK) begin
      pins_nxt[PIN_SYSOK] = 1'b1;
      pt                  = ST_RESET;
    end

    if (!done && pt == ST_RESET) begin
      pnp_nxt     = in_plt_rst_n && !rstlast_r;
      rstlast_nxt = in_plt_rst_n;
      if (in_sus_warn_n && level_nxt == LV_S5) begin
        // power-off: sus ack stays as it was
        pins_nxt[PIN_SYSOK] = 1'b0;
        pins_nxt[PIN_PCHOK] = 1'b0;
        pins_nxt[PIN_CTL]   = 1'b0;
        pins_nxt[PIN_RSM]   = 1'b0;
        pins_nxt[PIN_VDD5]  = 1'b0;
        phase_nxt  = ST_OFF_A;
        wcount_nxt = TIMER_WIDTH'(1);
        done       = 1'b1;
      end else begin
        pt = ST_LEDS;
      end
    end

    if (!done && pt == ST_OFF_A) begin
      pins_nxt[PIN_PRIM] = 1'b0;
      pins_nxt[PIN_DSW]  = 1'b0;
      phase_nxt  = ST_OFF_B;
      wcount_nxt = TIMER_WIDTH'(1);
      done       = 1'b1;
    end

    if (!done && pt == ST_OFF_B) begin
      level_nxt = level_of(in_susb_n, in_susc_n, pins_nxt[PIN_RSM]);
      pt        = ST_LEDS;
    end

    if (!done && pt == ST_LEDS) begin
      if (level_nxt == LV_S0) begin
        pins_nxt[PIN_LEDP] = 1'b1;
        pins_nxt[PIN_LEDA] = 1'b0;
      end else if (level_nxt == LV_S3) begin
        if (CMP_W'(blink_nxt) >= CMP_W'(cfg_r[REG_BLINK])) begin
          pins_nxt[PIN_LEDP] = !pins_nxt[PIN_LEDP];
          blink_nxt          = '0;
        end
        pins_nxt[PIN_LEDA] = 1'b0;
      end else if (!adapter_nxt) begin
        pins_nxt[PIN_LEDP] = 1'b0;
        pins_nxt[PIN_LEDA] = 1'b1;
      end else begin
        pins_nxt[PIN_LEDP] = 1'b0;
        pins_nxt[PIN_LEDA] = 1'b0;
      end
      done = 1'b1;
    end
  end

  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LV_DEFAULT;
      phase_r     <= ST_IDLE;
      wcount_r    <= '0;
      blink_r     <= '0;
      adapter_r   <= 1'b1;
      scip_r      <= 1'b1;
      button_r    <= 1'b1;
      pwrgd_r     <= 1'b0;
      rstlast_r   <= 1'b0;
      pins_r      <= PIN_W'(1) << PIN_BTN;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        level_r   <= level_nxt;
        phase_r   <= phase_nxt;
        wcount_r  <= wcount_nxt;
        blink_r   <= blink_nxt;
        adapter_r <= adapter_nxt;
        scip_r    <= scip_nxt;
        button_r  <= button_nxt;
        pwrgd_r   <= pwrgd_nxt;
        rstlast_r <= rstlast_nxt;
        pins_r    <= pins_nxt;
      end
    end
  end

  // pulse fields of the result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sci_r     <= sci_nxt;
      refresh_r <= refresh_nxt;
      pnp_r     <= pnp_nxt;
    end
  end

  // level fields come straight from the state, which only moves with a new result
  assign out_valid            = out_valid_r;
  assign out_rail_enables     = pins_r[PIN_CTL:PIN_PRIM];
  assign out_pwrok_pins       = pins_r[PIN_SYSOK:PIN_PCHOK];
  assign out_power_button_n   = pins_r[PIN_BTN];
  assign out_led_power        = pins_r[PIN_LEDP];
  assign out_led_adapter      = pins_r[PIN_LEDA];
  assign out_charger_enable   = pins_r[PIN_CHG];
  assign out_sci_send         = sci_r;
  assign out_refresh_request  = refresh_r;
  assign out_pnp_enable_pulse = pnp_r;
  assign out_power_level      = level_r;
  assign out_waiting          = (phase_r != ST_IDLE);

  assign wait_step  = in_fire && phase_r != ST_IDLE && wcount_r > TIMER_WIDTH'(1);
  assign wcount_dec = wcount_r - 1'b1;
  assign sci_src    = scip_r || refresh_nxt;

  `LPS_ASSERT_SAME(a_stall_holds_result, !in_ready, out_valid_r, "stall without a held result")
  `LPS_ASSERT_NEXT(a_wait_counts_down, wait_step, wcount_r == $past(wcount_dec), "timer stuck")
  `LPS_ASSERT_NEXT(a_wait_freezes_pins, wait_step, $stable(pins_r) && out_waiting, "pins moved")
  `LPS_ASSERT_SAME(a_sci_needs_accept, in_fire && sci_nxt, in_sci_accept && sci_src, "sci unasked")

endmodule
